// ===== sv/sorted_software_timer_scheduler_assert.svh =====
// Assertion macros for the sorted software timer scheduler.
`ifndef SORTED_SOFTWARE_TIMER_SCHEDULER_ASSERT_SVH
`define SORTED_SOFTWARE_TIMER_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define SST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sst assertion failed");
`define SST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sst assertion failed");
`else
`define SST_ASSERT_IMP(label, ante, cons)
`define SST_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/sst_pkg.sv =====
// Shared codes for the sorted software timer scheduler.
package sst_pkg;
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] LOP_NOP = 2'd0;
  localparam logic [1:0] LOP_INS = 2'd1;
  localparam logic [1:0] LOP_REM = 2'd2;

  localparam int unsigned MAX_FIRE = 16;

  typedef logic [1:0] list_op_t;
endpackage

// ===== sv/sst_alu.sv =====
// Shared add/subtract unit with carry out.
module sst_alu #(
  parameter int W = 33
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W:0]   y
);
  // Add, or subtract by two's complement; y[W] is carry (no borrow on subtract)
  assign y = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
endmodule

// ===== sv/sst_mem.sv =====
// Timer expiry, period and reload memories with registered read.
module sst_mem #(
  parameter int T   = 32,
  parameter int NUM = 16,
  parameter int IDW = 4
) (
  input  logic           clk,
  input  logic           exp_we,
  input  logic           aux_we,
  input  logic [IDW-1:0] waddr,
  input  logic [T-1:0]   wexp,
  input  logic [T-1:0]   wper,
  input  logic           wrel,
  input  logic [IDW-1:0] raddr,
  output logic [T-1:0]   rexp,
  output logic [T-1:0]   rper,
  output logic           rrel
);
  logic [T-1:0] exp_mem [NUM];
  logic [T:0]   aux_mem [NUM];

  // Write ports
  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[waddr] <= wexp;
    end
    if (aux_we) begin
      aux_mem[waddr] <= {wrel, wper};
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rexp <= exp_mem[raddr];
    {rrel, rper} <= aux_mem[raddr];
  end
endmodule

// ===== sv/sst_list.sv =====
// Ordered list of timer ids with insert and remove at a position.
module sst_list #(
  parameter int NUM = 16,
  parameter int IDW = 4,
  parameter int PW  = 4,
  parameter int CW  = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::list_op_t op,
  input  logic [PW-1:0]     pos,
  input  logic [IDW-1:0]    new_id,
  output logic [IDW-1:0]    rd_id,
  output logic [IDW-1:0]    head_id,
  output logic [CW-1:0]     count
);
  logic [IDW-1:0] slot_r [NUM];
  logic [IDW-1:0] slot_nxt [NUM];
  logic [CW-1:0]  count_r;

  assign rd_id   = slot_r[pos];
  assign head_id = slot_r[0];
  assign count   = count_r;

  // Shift entries locally for insert or remove
  always_comb begin
    for (int i = 0; i < NUM; i++) begin
      slot_nxt[i] = slot_r[i];
      if (op == sst_pkg::LOP_INS) begin
        if (PW'(i) == pos) begin
          slot_nxt[i] = new_id;
        end else if (PW'(i) > pos && i > 0) begin
          slot_nxt[i] = slot_r[(i > 0) ? i - 1 : 0];
        end
      end else if (op == sst_pkg::LOP_REM) begin
        if (PW'(i) >= pos && i < NUM - 1) begin
          slot_nxt[i] = slot_r[(i < NUM - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op == sst_pkg::LOP_INS) begin
      count_r <= count_r + CW'(1);
    end else if (op == sst_pkg::LOP_REM) begin
      count_r <= count_r - CW'(1);
    end
  end
endmodule

// ===== sv/sorted_software_timer_scheduler.sv =====
// Sorted software timer scheduler: sequencer around a shared add/subtract unit.
// Start/stop: busy through a removal scan if the timer is active, then for start a setup and insert walk.
// Tick: a head read and compare per timer; a fired auto-reload timer adds the catch-up
// remainder (negate, restoring division, two adjust steps) and an insert walk; then a finish step.
// One request at a time; busy falls in the cycle of the last result strobe; no receiver stall.
// Synchronous active-low reset clears the list count, active flags and sequencer.
module sorted_software_timer_scheduler #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_deadline,
  input  logic [31:0] in_reload_period,
  input  logic        in_auto_reload,
  input  logic [31:0] in_current_time,
  output logic        out_valid,
  output logic [3:0]  out_fired_id,
  output logic        out_fired,
  output logic        out_last
);
  localparam int T    = TICK_BITS;
  localparam int AW   = T + 1;
  localparam int IDW  = $clog2(NUM_TIMERS);
  localparam int PW   = IDW;
  localparam int CW   = $clog2(NUM_TIMERS + 1);
  localparam int CNTW = $clog2(T + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RM_SCAN = 4'd1;
  localparam logic [3:0] S_SETUP   = 4'd2;
  localparam logic [3:0] S_INS_RD  = 4'd3;
  localparam logic [3:0] S_INS_CMP = 4'd4;
  localparam logic [3:0] S_TK_RD   = 4'd5;
  localparam logic [3:0] S_TK_CMP  = 4'd6;
  localparam logic [3:0] S_NEG     = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_ADJ1    = 4'd9;
  localparam logic [3:0] S_ADJ2    = 4'd10;
  localparam logic [3:0] S_FINISH  = 4'd11;

  logic [3:0]     state_r;
  logic [1:0]     cmd_r;
  logic [IDW-1:0] id_r;
  logic [T-1:0]   ins_exp_r, now_r, per_r, exp_r, mag_r, r_r;
  logic           rel_r;
  logic [CW-1:0]  ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic [4:0]     fires_r;
  logic           pend_r;
  logic [IDW-1:0] pend_id_r;
  logic [NUM_TIMERS-1:0] active_r;
  logic           out_valid_r, out_fired_r, out_last_r;
  logic [3:0]     out_id_r;

  // Input conversion
  logic [63:0]    exp_ext, per_ext, now_ext;
  logic [7:0]     id_ext;
  logic [IDW-1:0] in_idx;
  logic           id_ok;
  logic [T-1:0]   per_sat;
  assign exp_ext = 64'(in_deadline);
  assign per_ext = 64'(in_reload_period);
  assign now_ext = 64'(in_current_time);
  assign id_ext  = 8'(in_timer_id);
  assign in_idx  = id_ext[IDW-1:0];
  assign id_ok   = 32'(id_ext) < 32'(NUM_TIMERS);
  assign per_sat = (per_ext > 64'({1'b0, {(T-1){1'b1}}})) ? {1'b0, {(T-1){1'b1}}}
                                                          : per_ext[T-1:0];

  // List, memories and adder
  sst_pkg::list_op_t lop;
  logic [PW-1:0]  lpos;
  logic [IDW-1:0] rd_id, head_id;
  logic [CW-1:0]  count;
  logic           exp_we, aux_we;
  logic [IDW-1:0] raddr;
  logic [T-1:0]   wexp, rexp, rper;
  logic           rrel;
  logic [AW-1:0]  alu_a, alu_b;
  logic           alu_sub;
  logic [AW:0]    alu_y;

  sst_list #(.NUM(NUM_TIMERS), .IDW(IDW), .PW(PW), .CW(CW)) u_list (
    .clk(clk), .rst_n(rst_n), .op(lop), .pos(lpos), .new_id(id_r),
    .rd_id(rd_id), .head_id(head_id), .count(count)
  );

  sst_mem #(.T(T), .NUM(NUM_TIMERS), .IDW(IDW)) u_mem (
    .clk(clk), .exp_we(exp_we), .aux_we(aux_we), .waddr(id_r), .wexp(wexp),
    .wper(per_r), .wrel(rel_r), .raddr(raddr), .rexp(rexp), .rper(rper), .rrel(rrel)
  );

  sst_alu #(.W(AW)) u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

  logic at_end, expired;
  assign at_end  = ptr_r >= count;
  assign lpos    = (state_r == S_TK_CMP) ? '0 : ptr_r[PW-1:0];
  assign expired = (alu_y[T-1:0] == '0) || alu_y[T-1];
  assign wexp    = (state_r == S_ADJ2) ? alu_y[T-1:0] : ins_exp_r;
  assign exp_we  = (state_r == S_SETUP) || (state_r == S_ADJ2);
  assign aux_we  = (state_r == S_SETUP);
  assign raddr   = (state_r == S_TK_RD) ? head_id : rd_id;

  // Route operands to the shared adder
  always_comb begin
    alu_a   = {1'b0, ins_exp_r};
    alu_b   = {1'b0, rexp};
    alu_sub = 1'b1;
    unique case (state_r)
      S_TK_CMP: begin
        alu_a = {1'b0, rexp};
        alu_b = {1'b0, now_r};
      end
      S_NEG: begin
        alu_a = {1'b0, now_r};
        alu_b = {1'b0, exp_r};
      end
      S_DIV: begin
        alu_a = {r_r, mag_r[T-1]};
        alu_b = {1'b0, per_r};
      end
      S_ADJ1: begin
        alu_a = {1'b0, per_r};
        alu_b = {1'b0, r_r};
      end
      S_ADJ2: begin
        alu_a   = {1'b0, now_r};
        alu_b   = {1'b0, r_r};
        alu_sub = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // List operation per state
  always_comb begin
    lop = sst_pkg::LOP_NOP;
    unique case (state_r)
      S_RM_SCAN: begin
        if (!at_end && rd_id == id_r) begin
          lop = sst_pkg::LOP_REM;
        end
      end
      S_INS_RD: begin
        if (at_end && 32'(count) < 32'(NUM_TIMERS)) begin
          lop = sst_pkg::LOP_INS;
        end
      end
      S_INS_CMP: begin
        if (alu_y[T-1]) begin
          lop = sst_pkg::LOP_INS;
        end
      end
      S_TK_CMP: begin
        if (expired) begin
          lop = sst_pkg::LOP_REM;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= in_command;
            id_r      <= in_idx;
            ins_exp_r <= exp_ext[T-1:0];
            per_r     <= per_sat;
            rel_r     <= in_auto_reload && (per_sat != '0);
            now_r     <= now_ext[T-1:0];
            ptr_r     <= '0;
            fires_r   <= '0;
            pend_r    <= 1'b0;
            priority if (in_command == sst_pkg::CMD_START && id_ok) begin
              state_r <= active_r[in_idx] ? S_RM_SCAN : S_SETUP;
            end else if (in_command == sst_pkg::CMD_STOP && id_ok) begin
              active_r[in_idx] <= 1'b0;
              state_r <= active_r[in_idx] ? S_RM_SCAN : S_FINISH;
            end else if (in_command == sst_pkg::CMD_TICK) begin
              state_r <= S_TK_RD;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_RM_SCAN: begin
          if (at_end || rd_id == id_r) begin
            state_r <= (cmd_r == sst_pkg::CMD_START) ? S_SETUP : S_FINISH;
          end else begin
            ptr_r <= ptr_r + CW'(1);
          end
        end
        S_SETUP: begin
          active_r[id_r] <= 1'b1;
          ptr_r   <= '0;
          state_r <= S_INS_RD;
        end
        S_INS_RD: begin
          if (at_end) begin
            state_r <= (cmd_r == sst_pkg::CMD_TICK) ? S_TK_RD : S_FINISH;
            ptr_r   <= '0;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (alu_y[T-1]) begin
            state_r <= (cmd_r == sst_pkg::CMD_TICK) ? S_TK_RD : S_FINISH;
            ptr_r   <= '0;
          end else begin
            ptr_r   <= ptr_r + CW'(1);
            state_r <= S_INS_RD;
          end
        end
        S_TK_RD: begin
          if (count == '0 || 32'(fires_r) >= sst_pkg::MAX_FIRE) begin
            state_r <= S_FINISH;
          end else begin
            id_r    <= head_id;
            state_r <= S_TK_CMP;
          end
        end
        S_TK_CMP: begin
          if (!expired) begin
            state_r <= S_FINISH;
          end else begin
            // Release the previous fired timer, hold this one until last is known
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_fired_r <= 1'b1;
              out_last_r  <= 1'b0;
              out_id_r    <= 4'(8'(pend_id_r));
            end
            pend_r    <= 1'b1;
            pend_id_r <= id_r;
            fires_r   <= fires_r + 5'd1;
            exp_r     <= rexp;
            per_r     <= rper;
            if (rrel) begin
              state_r <= S_NEG;
            end else begin
              active_r[id_r] <= 1'b0;
              state_r <= S_TK_RD;
            end
          end
        end
        S_NEG: begin
          mag_r   <= alu_y[T-1:0];
          r_r     <= '0;
          cnt_r   <= CNTW'(T);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // One restoring remainder step per cycle
          r_r   <= alu_y[AW] ? alu_y[T-1:0] : {r_r[T-2:0], mag_r[T-1]};
          mag_r <= {mag_r[T-2:0], 1'b0};
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= S_ADJ1;
          end
        end
        S_ADJ1: begin
          r_r     <= alu_y[T-1:0];
          state_r <= S_ADJ2;
        end
        S_ADJ2: begin
          ins_exp_r <= alu_y[T-1:0];
          ptr_r     <= '0;
          state_r   <= S_INS_RD;
        end
        S_FINISH: begin
          out_valid_r <= 1'b1;
          out_fired_r <= pend_r;
          out_last_r  <= 1'b1;
          out_id_r    <= pend_r ? 4'(8'(pend_id_r)) : 4'd0;
          pend_r      <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_fired    = out_fired_r;
  assign out_last     = out_last_r;
  assign out_fired_id = out_id_r;

`include "sorted_software_timer_scheduler_assert.svh"
  `SST_ASSERT_IMP(a_last_idle, out_valid && out_last, !busy)
  `SST_ASSERT_IMP(a_mid_busy, out_valid && !out_last, busy)
  `SST_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `SST_ASSERT_IMP(a_count_range, 1'b1, 32'(count) <= 32'(NUM_TIMERS))
endmodule
